// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sorted priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define SPQ_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Constants, codes and controller/datapath types shared across the block.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default number of queue entries
    localparam int CAPACITY = 16;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;          // capture the incoming transaction
        logic enq;           // insert held item into the cell row
        logic deq;           // shift the cell row towards the front
        logic write_result;  // load the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_deq;        // held transaction is a dequeue
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

// File: rtl/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channel interfaces
// Request channel (command, value, priority) and response channel.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic signed [spq_pkg::DATA_W-1:0]     item_value;
    logic signed [spq_pkg::DATA_W-1:0]     item_priority;

    modport source (output valid, output cmd, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_value, input item_priority,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [spq_pkg::DATA_W-1:0]     out_value;
    logic [spq_pkg::STATUS_W-1:0]          status;

    modport source (output valid, output out_value, output status, input ready);
    modport sink   (input valid, input out_value, input status, output ready);
endinterface

// File: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Two-state sequencer: captures a transaction, then executes it on the cell
// row and loads the response register once that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    input  spq_pkg::t_dp_stat  i_stat,
    output spq_pkg::t_dp_cmd   o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   w_slot_free;

    // Response register can take a result this cycle
    assign w_slot_free = !r_rsp_valid || i_rsp_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    o_ctl.write_result = 1'b1;
                    o_ctl.enq          = !i_stat.is_deq && !i_stat.full;
                    o_ctl.deq          = i_stat.is_deq && !i_stat.empty;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Response valid flag
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_ctl.write_result) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    // Assertions
    `SPQ_NEVER(a_enq_and_deq, i_clk, i_rst_n, o_ctl.enq && o_ctl.deq, "enq and deq together")
    `SPQ_ASSERT(a_write_in_exec, i_clk, i_rst_n, o_ctl.write_result |-> r_state == S_EXEC, "result written outside execute")
    `SPQ_ASSERT(a_rsp_from_write, i_clk, i_rst_n, $rose(r_rsp_valid) |-> $past(o_ctl.write_result), "response without result write")
    `SPQ_ASSERT(a_exec_returns, i_clk, i_rst_n, o_ctl.load |=> r_state == S_EXEC, "load did not enter execute")

endmodule

// File: rtl/spq_dp.sv
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Row of cells kept sorted by priority, front at cell 0. Each cell compares
// its own priority with the held item and picks keep, new item or neighbour.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_dp #(
    parameter int CAPACITY = spq_pkg::CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_cmd,
    input  logic signed [spq_pkg::DATA_W-1:0] i_in_value,
    input  logic signed [spq_pkg::DATA_W-1:0] i_in_priority,
    input  spq_pkg::t_dp_cmd                  i_ctl,
    output spq_pkg::t_dp_stat                 o_stat,
    output logic signed [spq_pkg::DATA_W-1:0] o_out_value,
    output spq_pkg::t_status                  o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Held transaction
    logic                              r_cmd;
    logic signed [spq_pkg::DATA_W-1:0] r_in_value;
    logic signed [spq_pkg::DATA_W-1:0] r_in_prio;

    // Cell row
    logic signed [spq_pkg::DATA_W-1:0] r_val [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] r_pri [CAPACITY];
    logic [CW-1:0]                     r_count;

    logic [CAPACITY-1:0]               w_ge;
    logic [CAPACITY-1:0]               w_take_new;
    logic signed [spq_pkg::DATA_W-1:0] w_prv_val [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] w_prv_pri [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] w_nxt_val [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] w_nxt_pri [CAPACITY];

    logic signed [spq_pkg::DATA_W-1:0] r_out_value;
    spq_pkg::t_status                  r_status;

    logic w_full, w_empty;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    // Capture incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd      <= i_in_cmd;
            r_in_value <= i_in_value;
            r_in_prio  <= i_in_priority;
        end
    end

    // Per-cell compare and neighbour selection
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        // occupied and at least as urgent as the new item: it stays ahead
        assign w_ge[g] = (CW'(g) < r_count) && (r_pri[g] >= r_in_prio);

        if (g == 0) begin : g_front
            assign w_take_new[g] = 1'b1;
            assign w_prv_val[g]  = r_in_value;
            assign w_prv_pri[g]  = r_in_prio;
        end else begin : g_body
            assign w_take_new[g] = w_ge[g-1];
            assign w_prv_val[g]  = r_val[g-1];
            assign w_prv_pri[g]  = r_pri[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign w_nxt_val[g] = r_val[g];
            assign w_nxt_pri[g] = r_pri[g];
        end else begin : g_mid
            assign w_nxt_val[g] = r_val[g+1];
            assign w_nxt_pri[g] = r_pri[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.enq && !w_ge[g]) begin
                if (w_take_new[g]) begin
                    r_val[g] <= r_in_value;
                    r_pri[g] <= r_in_prio;
                end else begin
                    r_val[g] <= w_prv_val[g];
                    r_pri[g] <= w_prv_pri[g];
                end
            end else if (i_ctl.deq) begin
                r_val[g] <= w_nxt_val[g];
                r_pri[g] <= w_nxt_pri[g];
            end
        end
    end

    // Occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.enq) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.deq) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (i_ctl.write_result) begin
            priority if (r_cmd == spq_pkg::CMD_DEQ && w_empty) begin
                r_out_value <= '0;
                r_status    <= spq_pkg::STATUS_EMPTY;
            end else if (r_cmd == spq_pkg::CMD_DEQ) begin
                r_out_value <= r_val[0];
                r_status    <= spq_pkg::STATUS_OK;
            end else if (w_full) begin
                r_out_value <= '0;
                r_status    <= spq_pkg::STATUS_FULL;
            end else begin
                r_out_value <= '0;
                r_status    <= spq_pkg::STATUS_OK;
            end
        end
    end

    assign o_stat.is_deq = (r_cmd == spq_pkg::CMD_DEQ);
    assign o_stat.full   = w_full;
    assign o_stat.empty  = w_empty;
    assign o_out_value   = r_out_value;
    assign o_status      = r_status;

    // Assertions
    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY), "count above capacity")
    `SPQ_ASSERT(a_enq_count, i_clk, i_rst_n, i_ctl.enq |=> r_count == $past(r_count) + CW'(1), "enqueue count step")
    `SPQ_ASSERT(a_deq_count, i_clk, i_rst_n, i_ctl.deq |=> r_count == $past(r_count) - CW'(1), "dequeue count step")
    `SPQ_ASSERT(a_enq_empty_front, i_clk, i_rst_n, (i_ctl.enq && w_empty) |=> r_val[0] == $past(r_in_value), "insert into empty queue missed front")

endmodule

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted by priority, highest first, equal priorities in
// arrival order. Enqueue inserts, dequeue returns the front value.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                          | Handshake
//  i_req    | in  | cmd, item_value, item_priority   | valid/ready
//  o_rsp    | out | out_value, status                | valid/ready
//
//  Each transaction is captured in S_IDLE, then executed in S_EXEC, where every
//  cell compares against the held priority and shifts or loads in parallel.
//  Exactly one response per request; status flags empty dequeue or full drop.
//  i_rst_n is synchronous, active low; it empties the queue (no clearing pass).
//  A new request is taken while the previous response waits; execution stalls
//  only while the response register is still held by the sink.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    spq_pkg::t_dp_cmd  w_ctl;
    spq_pkg::t_dp_stat w_stat;

    // Sequencer
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl)
    );

    // Cell row and response register
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_cmd      (i_req.cmd),
        .i_in_value    (i_req.item_value),
        .i_in_priority (i_req.item_priority),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .o_out_value   (o_rsp.out_value),
        .o_status      (o_rsp.status)
    );

endmodule

// File: tb/sv/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives enqueue and dequeue transactions through the request channel and
// checks every response against a behavioural copy of the sorted queue.
// The directed part covers the empty and full cases, equal priorities and
// the priority extremes. Mixed random traffic follows under three
// sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int RANDOM_ITEMS   = 450;   // per idle pattern, three patterns
    localparam int END_CYCLES     = 20;

    localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
    } t_queue_result;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the queue, front at index 0
    logic signed [DATA_W-1:0] shadow_value [CAPACITY];
    logic signed [DATA_W-1:0] shadow_prio  [CAPACITY];
    int                       shadow_count;

    t_queue_result pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int n_inserted;
    int n_removed;
    int n_empty_deq;
    int n_dropped;
    int n_checked;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("sorted_priority_queue_test failed");
        $finish;
    end

    // Work out the response of one operation and update the shadow queue
    function automatic t_queue_result apply_queue_op(input logic cmd,
                                                     input logic signed [DATA_W-1:0] value,
                                                     input logic signed [DATA_W-1:0] prio);
        t_queue_result res;
        int            pos;
        res.value  = '0;
        res.status = STATUS_OK;
        if (cmd == CMD_ENQ) begin
            if (shadow_count >= CAPACITY) begin
                res.status = STATUS_FULL;
                n_dropped++;
            end else begin
                // walk past every entry of greater or equal priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= prio)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = value;
                shadow_prio[pos]  = prio;
                shadow_count++;
                n_inserted++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = STATUS_EMPTY;
                n_empty_deq++;
            end else begin
                res.value = shadow_value[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_prio[i-1]  = shadow_prio[i];
                end
                shadow_count--;
                n_removed++;
            end
        end
        return res;
    endfunction

    // Transaction monitor: predict on request, compare on response
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                pending_results.push_back(apply_queue_op(req_ch.cmd, req_ch.item_value,
                                                         req_ch.item_priority));
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("response transaction with no request outstanding");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (rsp_ch.out_value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value,
                               rsp_ch.out_value);
                        fail_count++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               rsp_ch.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Response back-pressure
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send one request transaction; called and returns at a falling edge
    task automatic send_op(input logic cmd, input logic signed [DATA_W-1:0] value,
                           input logic signed [DATA_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.cmd           = cmd;
        req_ch.item_value    = value;
        req_ch.item_priority = prio;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every outstanding response is back
    task automatic drain_responses();
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_empty_dequeue();
        send_op(CMD_DEQ, PRIO_MAX, PRIO_MIN);
        send_op(CMD_DEQ, PRIO_MIN, PRIO_MAX);
    endtask

    // Fill to capacity with extremes and equal priorities, then overflow
    task automatic test_fill_to_capacity();
        logic signed [DATA_W-1:0] fill_prio [16] = '{
            32'sd5, 32'sd5, PRIO_MAX, PRIO_MIN, 32'sd0, -32'sd1, 32'sd5, PRIO_MAX,
            PRIO_MIN, -32'sd1, 32'sd3, 32'sd3, 32'sd100, -32'sd100, 32'sd0, 32'sd7};
        logic signed [DATA_W-1:0] fill_value [16] = '{
            PRIO_MAX, PRIO_MIN, 32'sd0, -32'sd1, 32'sd11, 32'sd12, 32'sd13, 32'sd14,
            32'sd15, 32'sd16, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd19, 32'sd20,
            32'sd21, 32'sd22};
        for (int k = 0; k < CAPACITY && k < 16; k++)
            send_op(CMD_ENQ, fill_value[k], fill_prio[k]);
        // dropped even at the top priority
        send_op(CMD_ENQ, 32'sh5a5a_a5a5, PRIO_MAX);
    endtask

    task automatic test_front_order();
        repeat (4) send_op(CMD_DEQ, '0, '0);
        drain_responses();
    endtask

    // Runs of insert-heavy or remove-heavy traffic so the queue swings
    // between empty and full
    task automatic test_random_traffic(input int n_items);
        int                       enq_bias;
        int                       run_left;
        logic                     cmd;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
        run_left = 0;
        enq_bias = 50;
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                enq_bias = $urandom_range(1) ? 80 : 25;
                run_left = $urandom_range(40, 8);
            end
            run_left--;
            cmd   = ($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
            value = $urandom();
            case ($urandom_range(3))
                0: prio = $signed($urandom_range(6)) - 32'sd3;  // many ties
                1: case ($urandom_range(3))
                       0: prio = PRIO_MAX;
                       1: prio = PRIO_MIN;
                       2: prio = 32'sd0;
                       default: prio = -32'sd1;
                   endcase
                default: prio = $urandom();
            endcase
            send_op(cmd, value, prio);
            if ($urandom_range(149) == 0)
                drain_responses();
        end
        drain_responses();
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_ENQ;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        shadow_count         = 0;
        fail_count           = 0;
        n_inserted           = 0;
        n_removed            = 0;
        n_empty_deq          = 0;
        n_dropped            = 0;
        n_checked            = 0;
        send_idle_pct        = 33;
        recv_idle_pct        = 64;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_dequeue();
        test_fill_to_capacity();
        test_front_order();
        test_random_traffic(RANDOM_ITEMS);

        send_idle_pct = 64;
        recv_idle_pct = 33;
        test_random_traffic(RANDOM_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        drain_responses();
        repeat (END_CYCLES) @(negedge i_clk);

        $display("Checked %0d responses: %0d inserts, %0d removals,", n_checked,
                 n_inserted, n_removed);
        $display("%0d dequeues on an empty queue, %0d inserts dropped when full.",
                 n_empty_deq, n_dropped);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("sorted_priority_queue_test passed");
        end else begin
            $display("sorted_priority_queue_test failed");
        end
        $finish;
    end

endmodule
